// ===== rtl/gtm_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gtm_pkg: shared types and constants of the GHASH table multiplier
// 128-bit field element type, the queued request, register indexes and the
// GF(2^128) multiply-by-x step in GCM reflected bit order.
// ============================================================================
package gtm_pkg;

    typedef logic [127:0] gtm_word_t;

    // One masked block on its way from the front end to the multiplier
    typedef struct packed {
        gtm_word_t data;
        logic      first;
    } gtm_req_t;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOW  = 2'd1;

    localparam int QUEUE_DEPTH = 2;

    // x^128 + x^7 + x^2 + x + 1, reflected: folds into the top byte
    localparam gtm_word_t GTM_POLY = {8'he1, 120'd0};

    // Multiply by x: coefficients move toward bit 0, x^127 folds back
    function automatic gtm_word_t gtm_times_x(input gtm_word_t v);
        return (v >> 1) ^ (v[0] ? GTM_POLY : '0);
    endfunction

endpackage

// ===== rtl/gtm_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gtm_front: request intake
// Zeroes the bytes past the valid count and holds the masked block in a
// register until the queue takes it.
// ============================================================================
module gtm_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [63:0]       block_high,
    input  logic [63:0]       block_low,
    input  logic [4:0]        valid_bytes,
    input  logic              first_block,
    output logic              req_valid,
    input  logic              req_ready,
    output gtm_pkg::gtm_req_t req
);
    import gtm_pkg::*;

    logic      front_valid_reg;
    gtm_req_t  front_req_reg;
    gtm_word_t mask;
    gtm_word_t block;

    // byte 0 sits in the top bits; counts above sixteen keep every byte
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            mask[127 - 8*i -: 8] = (5'(i) < valid_bytes) ? 8'hff : 8'h00;
        end
        block = {block_high, block_low} & mask;
    end

    assign in_ready  = !front_valid_reg || req_ready;
    assign req_valid = front_valid_reg;
    assign req       = front_req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            front_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            front_req_reg.data  <= block;
            front_req_reg.first <= first_block;
        end
    end

endmodule

// ===== rtl/gtm_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gtm_queue: request queue
// Short FIFO between the intake and the multiplier.
// ============================================================================
module gtm_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  gtm_pkg::gtm_req_t push_req,
    output logic              pop_valid,
    input  logic              pop_ready,
    output gtm_pkg::gtm_req_t pop_req
);
    import gtm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    gtm_req_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_req    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

// ===== rtl/gtm_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gtm_back: digit-serial GF(2^128) multiplier
// Holds H and the accumulator; multiplies one digit per cycle, highest
// degree first, and registers the result for the output channel.
// ============================================================================
module gtm_back
#(
    parameter int DIGIT_BITS = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [gtm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  gtm_pkg::gtm_req_t             req,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [63:0]                   hash_high,
    output logic [63:0]                   hash_low
);
    import gtm_pkg::*;

    localparam int NUM_DIGITS = (128 + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int PAD_W      = NUM_DIGITS * DIGIT_BITS;
    localparam int PAD        = PAD_W - 128;
    localparam int CNT_W      = $clog2(NUM_DIGITS);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [63:0]       key_high_reg;
    logic [63:0]       key_low_reg;
    gtm_word_t         acc_reg;
    gtm_word_t         z_reg;
    logic [PAD_W-1:0]  opnd_reg;
    logic              out_valid_reg;
    logic [63:0]       hash_high_reg;
    logic [63:0]       hash_low_reg;

    gtm_word_t             base [DIGIT_BITS];
    gtm_word_t             entry;
    gtm_word_t             z_next;
    gtm_word_t             acc_op;
    logic [DIGIT_BITS-1:0] digit;
    logic                  out_load;

    // Table entry for a digit = XOR of H*x^j for its set bits; digit MSB
    // selects H itself
    always_comb
    begin
        base[0] = {key_high_reg, key_low_reg};
        for (int j = 1; j < DIGIT_BITS; j++)
        begin
            base[j] = gtm_times_x(base[j-1]);
        end
        digit = opnd_reg[DIGIT_BITS-1:0];
        entry = '0;
        for (int j = 0; j < DIGIT_BITS; j++)
        begin
            entry = entry ^ (digit[DIGIT_BITS-1-j] ? base[j] : '0);
        end
        z_next = z_reg;
        for (int s = 0; s < DIGIT_BITS; s++)
        begin
            z_next = gtm_times_x(z_next);
        end
        z_next = z_next ^ entry;
        acc_op = (req.first ? '0 : acc_reg) ^ req.data;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign hash_high = hash_high_reg;
    assign hash_low  = hash_low_reg;

    // result moves into the output register once that register is free
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            key_high_reg  <= '0;
            key_low_reg   <= '0;
            acc_reg       <= '0;
            z_reg         <= '0;
            opnd_reg      <= '0;
            out_valid_reg <= 1'b0;
            hash_high_reg <= '0;
            hash_low_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_KEY_HIGH)
                begin
                    key_high_reg <= cfg_data;
                end
                else if (cfg_index == CFG_KEY_LOW)
                begin
                    key_low_reg <= cfg_data;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        // padding below x^127 stays zero in the low bits
                        opnd_reg  <= PAD_W'(acc_op) << PAD;
                        z_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    z_reg    <= z_next;
                    opnd_reg <= opnd_reg >> DIGIT_BITS;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(NUM_DIGITS - 1))
                    begin
                        acc_reg   <= z_next;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        hash_high_reg <= acc_reg[127:64];
                        hash_low_reg  <= acc_reg[63:0];
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/ghash_table_multiplier.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ghash_table_multiplier: GCM GHASH engine
// Absorbs one 128-bit block per request into the running hash and
// multiplies it by the subkey H over GF(2^128), one digit per cycle.
// ============================================================================
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | sink      | in_valid / in_ready  | block_high, block_low,
//          |           |                      | valid_bytes, first_block
//  out     | source    | out_valid / out_ready| hash_high, hash_low
//  cfg     | sink      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Each request passes through a load step, the multiplier loop over
// ceil(128/DIGIT_BITS) digits (32 at the default 4-bit digit) and a result
// step; the multiplier takes no new request until its result has moved on.
// Reset clears the hash key (so H = 0), the accumulator and all handshakes.
// The intake register and a two-entry queue let requests arrive while the
// multiplier is busy; a result waiting on out_ready stalls the loop and, in turn, the intake.
// Config writes are always taken; index 0 is the high key half, 1 the low,
// others are ignored.
//
module ghash_table_multiplier
#(
    parameter int DIGIT_BITS = 4
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [63:0]                     block_high,
    input  logic [63:0]                     block_low,
    input  logic [4:0]                      valid_bytes,
    input  logic                            first_block,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [63:0]                     hash_high,
    output logic [63:0]                     hash_low,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gtm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]                     cfg_data
);
    import gtm_pkg::*;

    // front -> queue
    logic     fq_valid;
    logic     fq_ready;
    gtm_req_t fq_req;

    // queue -> multiplier
    logic     qb_valid;
    logic     qb_ready;
    gtm_req_t qb_req;

    // key registers live in the multiplier, which never refuses a write
    assign cfg_ready = 1'b1;

    // mask the partial block and park it
    gtm_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .block_high  (block_high),
        .block_low   (block_low),
        .valid_bytes (valid_bytes),
        .first_block (first_block),
        .req_valid   (fq_valid),
        .req_ready   (fq_ready),
        .req         (fq_req)
    );

    // decouple intake from the multiply loop
    gtm_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_req   (fq_req),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_req    (qb_req)
    );

    // accumulate, multiply by H digit by digit, register the result
    gtm_back #(.DIGIT_BITS(DIGIT_BITS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (qb_valid),
        .req_ready (qb_ready),
        .req       (qb_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hash_high (hash_high),
        .hash_low  (hash_low)
    );

endmodule
